/* hdl/pfr_pkg.sv */
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants and types for the parameter frame receiver: frame codes,
// store geometry and the sequencer state type.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int WORD_COUNT    = 14;
    localparam int PAYLOAD_BYTES = 56;

    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 32;
    localparam int WORD_INDEX_W = 4;

    localparam int CNT_W       = $clog2(PAYLOAD_BYTES + 1);
    localparam int STORE_WORDS = (PAYLOAD_BYTES + 3) / 4;
    localparam int SADDR_W     = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int ISSUE_W     = $clog2(WORD_COUNT + 1);
    localparam int WIDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    localparam logic [BYTE_W-1:0] HDR_FIRST   = 8'h55;
    localparam logic [BYTE_W-1:0] HDR_SECOND  = 8'hAA;
    localparam logic [BYTE_W-1:0] TRAILER     = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_READ    = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_CAPTURE = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_BEEP    = 8'h03;

    localparam logic [1:0] LANE_0 = 2'd0;
    localparam logic [1:0] LANE_1 = 2'd1;
    localparam logic [1:0] LANE_2 = 2'd2;
    localparam logic [1:0] LANE_3 = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

endpackage

/* hdl/pfr_ram.sv */
// ----------------------------------------------------------------------------
// pfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/param_frame_receiver.sv */
// ----------------------------------------------------------------------------
// param_frame_receiver
// Watches a serial byte stream for 0x55 0xAA headers and their command byte,
// captures the payload into a word store and reads out the parameter words
// when a frame closes with its trailer.
// ----------------------------------------------------------------------------
//  channel | signals                    | beat carries
//  --------+----------------------------+--------------------------------------
//  in      | in_valid / in_ready        | rx_byte
//  out     | out_valid / out_ready      | word_valid, word_index, word_bits,
//          |                            | read_request, ack_beep, run_end
//
//  A command gives one beat, registered in the cycle after its byte is taken.
//  A closing trailer starts a readout of WORD_COUNT beats, one word per cycle
//  from the store RAM read port while the output is not stalled.
//  in_ready is low during readout and while a beat is waiting and not taken.
//  Output stalls hold the readout; the RAM output holds the next word.
//  Reset clears control state only; the store needs no clearing.
// ----------------------------------------------------------------------------
module param_frame_receiver (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [pfr_pkg::BYTE_W-1:0]        rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              word_valid,
    output logic [pfr_pkg::WORD_INDEX_W-1:0]  word_index,
    output logic [pfr_pkg::WORD_W-1:0]        word_bits,
    output logic                              read_request,
    output logic                              ack_beep,
    output logic                              run_end
);

    pfr_pkg::state_t state_reg, state_next;

    logic [pfr_pkg::BYTE_W-1:0]  prev_reg, prev_next;
    logic [pfr_pkg::BYTE_W-1:0]  prev2_reg, prev2_next;
    logic                        capturing_reg, capturing_next;
    logic [pfr_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [pfr_pkg::WORD_W-1:0]  acc_reg, acc_next;

    logic [pfr_pkg::ISSUE_W-1:0] issue_idx_reg, issue_idx_next;
    logic                        rd_pend_reg, rd_pend_next;
    logic [pfr_pkg::WIDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic                        pend_zero_reg, pend_zero_next;

    logic                              out_valid_reg, out_valid_next;
    logic                              word_valid_reg, word_valid_next;
    logic [pfr_pkg::WORD_INDEX_W-1:0]  word_index_reg, word_index_next;
    logic [pfr_pkg::WORD_W-1:0]        word_bits_reg, word_bits_next;
    logic                              read_request_reg, read_request_next;
    logic                              ack_beep_reg, ack_beep_next;
    logic                              run_end_reg, run_end_next;

    logic                        in_fire;
    logic                        out_free;
    logic                        hdr_seen;
    logic                        cap_store;
    logic                        cap_end;
    logic                        emit_words;
    logic                        cmd_rq;
    logic                        cmd_bp;
    logic                        cmd_cap;
    logic [1:0]                  lane;
    logic [pfr_pkg::CNT_W-1:0]   count_word;

    logic                        issue;
    logic                        issue_in_store;
    logic                        load_word;
    logic                        last_load;

    logic                        ram_we;
    logic [pfr_pkg::SADDR_W-1:0] ram_waddr;
    logic                        ram_re;
    logic [pfr_pkg::SADDR_W-1:0] ram_raddr;
    logic [pfr_pkg::WORD_W-1:0]  ram_rdata;

    pfr_ram #(
        .WIDTH (pfr_pkg::WORD_W),
        .DEPTH (pfr_pkg::STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (acc_next),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // byte decode
    always_comb
    begin
        out_free   = !out_valid_reg || out_ready;
        in_fire    = in_valid && in_ready;
        hdr_seen   = (prev2_reg == pfr_pkg::HDR_FIRST) && (prev_reg == pfr_pkg::HDR_SECOND);
        cap_store  = capturing_reg && (32'(count_reg) < pfr_pkg::PAYLOAD_BYTES);
        cap_end    = capturing_reg && !(32'(count_reg) < pfr_pkg::PAYLOAD_BYTES);
        emit_words = cap_end && (rx_byte == pfr_pkg::TRAILER);
        cmd_rq     = hdr_seen && (rx_byte == pfr_pkg::CMD_READ);
        cmd_cap    = hdr_seen && (rx_byte == pfr_pkg::CMD_CAPTURE);
        cmd_bp     = hdr_seen && ((rx_byte == pfr_pkg::CMD_READ)
                                  || (rx_byte == pfr_pkg::CMD_CAPTURE)
                                  || (rx_byte == pfr_pkg::CMD_BEEP));
        lane       = count_reg[1:0];
        count_word = count_reg >> 2;
    end

    // readout control
    always_comb
    begin
        issue_in_store = 32'(issue_idx_reg) < pfr_pkg::STORE_WORDS;
        load_word      = (state_reg == pfr_pkg::ST_EMIT) && rd_pend_reg && out_free;
        issue          = (state_reg == pfr_pkg::ST_EMIT)
                         && (32'(issue_idx_reg) < pfr_pkg::WORD_COUNT)
                         && (!rd_pend_reg || load_word);
        last_load      = load_word && (32'(pend_idx_reg) == pfr_pkg::WORD_COUNT - 1);
        ram_re         = issue && issue_in_store;
        ram_raddr      = pfr_pkg::SADDR_W'(issue_idx_reg);
        ram_we         = in_fire && cap_store
                         && ((lane == pfr_pkg::LANE_3)
                             || (32'(count_reg) == pfr_pkg::PAYLOAD_BYTES - 1));
        ram_waddr      = count_word[pfr_pkg::SADDR_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfr_pkg::ST_IDLE:
            begin
                if (in_fire && emit_words)
                begin
                    state_next = pfr_pkg::ST_EMIT;
                end
            end
            pfr_pkg::ST_EMIT:
            begin
                if (last_load)
                begin
                    state_next = pfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfr_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs and datapath
    always_comb
    begin
        in_ready = (state_reg == pfr_pkg::ST_IDLE) && out_free;

        prev_next      = prev_reg;
        prev2_next     = prev2_reg;
        capturing_next = capturing_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;

        issue_idx_next = issue_idx_reg;
        rd_pend_next   = rd_pend_reg;
        pend_idx_next  = pend_idx_reg;
        pend_zero_next = pend_zero_reg;

        out_valid_next    = out_valid_reg && !out_ready;
        word_valid_next   = word_valid_reg;
        word_index_next   = word_index_reg;
        word_bits_next    = word_bits_reg;
        read_request_next = read_request_reg;
        ack_beep_next     = ack_beep_reg;
        run_end_next      = run_end_reg;

        case (lane)
            pfr_pkg::LANE_0: acc_next = {24'd0, rx_byte};
            pfr_pkg::LANE_1: acc_next = {acc_reg[31:16], rx_byte, acc_reg[7:0]};
            pfr_pkg::LANE_2: acc_next = {acc_reg[31:24], rx_byte, acc_reg[15:0]};
            pfr_pkg::LANE_3: acc_next = {rx_byte, acc_reg[23:0]};
            default:         acc_next = acc_reg;
        endcase

        if (in_fire)
        begin
            prev_next  = rx_byte;
            prev2_next = prev_reg;
            if (cap_store)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (cap_end)
            begin
                count_next     = '0;
                capturing_next = 1'b0;
            end
            if (cmd_cap)
            begin
                count_next     = '0;
                capturing_next = 1'b1;
            end
            if (emit_words)
            begin
                issue_idx_next = '0;
                rd_pend_next   = 1'b0;
            end
            else if (cmd_rq || cmd_bp)
            begin
                out_valid_next    = 1'b1;
                word_valid_next   = 1'b0;
                word_index_next   = '0;
                word_bits_next    = '0;
                read_request_next = cmd_rq;
                ack_beep_next     = cmd_bp;
                run_end_next      = 1'b1;
            end
        end
        else
        begin
            acc_next = acc_reg;
        end

        if (load_word)
        begin
            rd_pend_next      = 1'b0;
            out_valid_next    = 1'b1;
            word_valid_next   = 1'b1;
            word_index_next   = pfr_pkg::WORD_INDEX_W'(pend_idx_reg);
            word_bits_next    = pend_zero_reg ? '0 : ram_rdata;
            read_request_next = last_load;
            ack_beep_next     = last_load;
            run_end_next      = last_load;
        end

        if (issue)
        begin
            rd_pend_next   = 1'b1;
            pend_idx_next  = pfr_pkg::WIDX_W'(issue_idx_reg);
            pend_zero_next = !issue_in_store;
            issue_idx_next = issue_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pfr_pkg::ST_IDLE;
            prev_reg      <= '0;
            prev2_reg     <= '0;
            capturing_reg <= 1'b0;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            prev2_reg     <= prev2_next;
            capturing_reg <= capturing_next;
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg          <= acc_next;
        pend_idx_reg     <= pend_idx_next;
        pend_zero_reg    <= pend_zero_next;
        word_valid_reg   <= word_valid_next;
        word_index_reg   <= word_index_next;
        word_bits_reg    <= word_bits_next;
        read_request_reg <= read_request_next;
        ack_beep_reg     <= ack_beep_next;
        run_end_reg      <= run_end_next;
    end

    assign out_valid    = out_valid_reg;
    assign word_valid   = word_valid_reg;
    assign word_index   = word_index_reg;
    assign word_bits    = word_bits_reg;
    assign read_request = read_request_reg;
    assign ack_beep     = ack_beep_reg;
    assign run_end      = run_end_reg;

endmodule

/* hdl/pfr_checker.sv */
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks for the parameter frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module pfr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              word_valid,
    input logic [pfr_pkg::WORD_INDEX_W-1:0]  word_index,
    input logic [pfr_pkg::WORD_W-1:0]        word_bits,
    input logic                              read_request,
    input logic                              ack_beep,
    input logic                              run_end
);

    a_last_word_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_valid && run_end
        |-> word_index == pfr_pkg::WORD_INDEX_W'(pfr_pkg::WORD_COUNT - 1))
        else $error("last word beat has wrong index");

    a_cmd_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !word_valid
        |-> run_end && (word_bits == '0) && (word_index == '0) && (read_request || ack_beep))
        else $error("command beat malformed");

    a_mid_word_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_valid && !run_end |-> !read_request && !ack_beep && !in_ready)
        else $error("flags or input open before last word");

    a_readout_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && word_valid && !run_end |=> out_valid && word_valid)
        else $error("readout word missing after a taken beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_bits) && $stable(word_index))
        else $error("stalled output beat changed");

endmodule

bind param_frame_receiver pfr_checker u_pfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word_valid   (word_valid),
    .word_index   (word_index),
    .word_bits    (word_bits),
    .read_request (read_request),
    .ack_beep     (ack_beep),
    .run_end      (run_end)
);

/* test/tb_param_frame_receiver.sv */
// ----------------------------------------------------------------------------
// tb_param_frame_receiver
// Self-checking bench for the parameter frame receiver. A short table of
// header and command bytes comes first, then random frames: clean frames,
// frames with commands or restarts in the payload, wrong trailers, a trailer
// that is also a command, and loose noise. Each output beat is compared with
// a table row's beat or a behavioral copy that tracks header, capture, store.
// ----------------------------------------------------------------------------
module tb_param_frame_receiver;

    import pfr_pkg::*;

    localparam int ITEM_COUNT   = 280;
    localparam int TAIL_ITEMS   = 60;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic                    word_valid;
        logic [WORD_INDEX_W-1:0] word_index;
        logic [WORD_W-1:0]       word_bits;
        logic                    read_request;
        logic                    ack_beep;
        logic                    run_end;
    } param_beat_t;

    typedef enum logic [1:0] {
        FROM_MODEL,
        TYPED_NONE,
        TYPED_FLAG_BEAT
    } row_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        row_kind_t         kind;
        logic              rq;
        logic              bp;
    } stim_row_t;

    typedef enum logic [2:0] {
        FR_GOOD,
        FR_BAD_TRAILER,
        FR_TRAILER_CMD,
        FR_RESTART,
        FR_CMD_INSIDE,
        FR_NOISE
    } frame_kind_t;

    localparam int DIR_N = 26;
    localparam stim_row_t DIR_ROWS [DIR_N] = '{
        '{8'h00,       TYPED_NONE,      1'b0, 1'b0},
        '{8'hFF,       TYPED_NONE,      1'b0, 1'b0},
        '{HDR_SECOND,  TYPED_NONE,      1'b0, 1'b0},
        '{HDR_FIRST,   TYPED_NONE,      1'b0, 1'b0},
        '{HDR_FIRST,   TYPED_NONE,      1'b0, 1'b0},
        '{HDR_SECOND,  TYPED_NONE,      1'b0, 1'b0},
        '{CMD_READ,    TYPED_FLAG_BEAT, 1'b1, 1'b1},
        '{HDR_FIRST,   TYPED_NONE,      1'b0, 1'b0},
        '{HDR_SECOND,  TYPED_NONE,      1'b0, 1'b0},
        '{CMD_BEEP,    TYPED_FLAG_BEAT, 1'b0, 1'b1},
        '{HDR_FIRST,   TYPED_NONE,      1'b0, 1'b0},
        '{HDR_SECOND,  TYPED_NONE,      1'b0, 1'b0},
        '{8'h00,       TYPED_NONE,      1'b0, 1'b0},
        '{HDR_FIRST,   TYPED_NONE,      1'b0, 1'b0},
        '{HDR_SECOND,  TYPED_NONE,      1'b0, 1'b0},
        '{8'hFF,       TYPED_NONE,      1'b0, 1'b0},
        '{HDR_FIRST,   TYPED_NONE,      1'b0, 1'b0},
        '{HDR_SECOND,  TYPED_NONE,      1'b0, 1'b0},
        '{8'h04,       TYPED_NONE,      1'b0, 1'b0},
        '{CMD_READ,    TYPED_NONE,      1'b0, 1'b0},
        '{HDR_FIRST,   TYPED_NONE,      1'b0, 1'b0},
        '{HDR_SECOND,  TYPED_NONE,      1'b0, 1'b0},
        '{CMD_CAPTURE, TYPED_FLAG_BEAT, 1'b0, 1'b1},
        '{HDR_FIRST,   FROM_MODEL,      1'b0, 1'b0},
        '{HDR_SECOND,  FROM_MODEL,      1'b0, 1'b0},
        '{CMD_READ,    FROM_MODEL,      1'b0, 1'b0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [BYTE_W-1:0]       rx_byte = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    word_valid;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [WORD_W-1:0]       word_bits;
    logic                    read_request;
    logic                    ack_beep;
    logic                    run_end;

    // receiver copy
    logic [BYTE_W-1:0] last_byte = '0;
    logic [BYTE_W-1:0] older_byte = '0;
    logic              capturing = 1'b0;
    int                fill_count = 0;
    logic [BYTE_W-1:0] payload_copy [PAYLOAD_BYTES];

    param_beat_t       step_beats [$];
    param_beat_t       beats_due [$];
    logic [BYTE_W-1:0] burst_bytes [$];

    bit gaps_on = 1'b0;
    bit hold_pending = 1'b0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int frames_read = 0;
    int flag_beats = 0;
    int words_checked = 0;

    param_frame_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word_valid   (word_valid),
        .word_index   (word_index),
        .word_bits    (word_bits),
        .read_request (read_request),
        .ack_beep     (ack_beep),
        .run_end      (run_end)
    );

    always #6 clk = ~clk;

    function automatic void advance_frame_state(input logic [BYTE_W-1:0] rx);
        logic              emit;
        logic              rq;
        logic              bp;
        logic [WORD_W-1:0] w;
        emit = 1'b0;
        rq   = 1'b0;
        bp   = 1'b0;
        step_beats.delete();
        if (capturing)
        begin
            if (fill_count < PAYLOAD_BYTES)
            begin
                payload_copy[fill_count] = rx;
                fill_count++;
            end
            else
            begin
                fill_count = 0;
                capturing  = 1'b0;
                if (rx == TRAILER)
                begin
                    emit = 1'b1;
                    rq   = 1'b1;
                    bp   = 1'b1;
                end
            end
        end
        if (older_byte == HDR_FIRST && last_byte == HDR_SECOND)
        begin
            if (rx == CMD_READ)
            begin
                rq = 1'b1;
                bp = 1'b1;
            end
            else if (rx == CMD_CAPTURE)
            begin
                fill_count = 0;
                capturing  = 1'b1;
                bp         = 1'b1;
            end
            else if (rx == CMD_BEEP)
                bp = 1'b1;
        end
        older_byte = last_byte;
        last_byte  = rx;
        if (emit)
        begin
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                w = '0;
                for (int k = 0; k < 4; k++)
                    if (4 * i + k < PAYLOAD_BYTES)
                        w[8*k +: 8] = payload_copy[4 * i + k];
                step_beats.push_back('{1'b1, WORD_INDEX_W'(i), w,
                                       (i == WORD_COUNT - 1) ? rq : 1'b0,
                                       (i == WORD_COUNT - 1) ? bp : 1'b0,
                                       i == WORD_COUNT - 1});
            end
            frames_read++;
        end
        else if (rq || bp)
        begin
            step_beats.push_back('{1'b0, '0, '0, rq, bp, 1'b1});
            flag_beats++;
        end
    endfunction

    function automatic void log_mismatch(input string what, input param_beat_t want,
                                         input param_beat_t seen);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $write("%s: expected valid=%0b idx=%0d bits=%08h rq=%0b beep=%0b end=%0b",
                   what, want.word_valid, want.word_index, want.word_bits,
                   want.read_request, want.ack_beep, want.run_end);
            $display(" | got valid=%0b idx=%0d bits=%08h rq=%0b beep=%0b end=%0b",
                     seen.word_valid, seen.word_index, seen.word_bits,
                     seen.read_request, seen.ack_beep, seen.run_end);
        end
    endfunction

    function automatic void build_sequence(input frame_kind_t kind);
        logic [BYTE_W-1:0] pay [PAYLOAD_BYTES];
        logic [BYTE_W-1:0] trailer;
        int                pos;
        int                lead;
        burst_bytes.delete();
        foreach (pay[i])
            pay[i] = BYTE_W'($urandom_range(0, 255));
        trailer = TRAILER;
        case (kind)
            FR_BAD_TRAILER:
            begin
                trailer = BYTE_W'($urandom_range(0, 255));
                if (trailer == TRAILER)
                    trailer = 8'hFF;
                if ($urandom_range(0, 2) == 0)
                    trailer = CMD_BEEP;
            end
            FR_TRAILER_CMD:
            begin
                pay[PAYLOAD_BYTES - 2] = HDR_FIRST;
                pay[PAYLOAD_BYTES - 1] = HDR_SECOND;
            end
            FR_RESTART:
            begin
                lead = $urandom_range(0, 50);
                burst_bytes.push_back(HDR_FIRST);
                burst_bytes.push_back(HDR_SECOND);
                burst_bytes.push_back(CMD_CAPTURE);
                for (int i = 0; i < lead; i++)
                    burst_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
            end
            FR_CMD_INSIDE:
            begin
                pos = $urandom_range(0, PAYLOAD_BYTES - 3);
                pay[pos]     = HDR_FIRST;
                pay[pos + 1] = HDR_SECOND;
                case ($urandom_range(0, 3))
                    0: pay[pos + 2] = CMD_READ;
                    1: pay[pos + 2] = CMD_BEEP;
                    2: pay[pos + 2] = CMD_READ;
                    default: pay[pos + 2] = BYTE_W'($urandom_range(4, 255));
                endcase
            end
            default:
            begin
            end
        endcase
        if (kind == FR_NOISE)
        begin
            lead = $urandom_range(1, 8);
            for (int i = 0; i < lead; i++)
                case ($urandom_range(0, 5))
                    0: burst_bytes.push_back(HDR_FIRST);
                    1: burst_bytes.push_back(HDR_SECOND);
                    2: burst_bytes.push_back(CMD_READ);
                    3: burst_bytes.push_back(CMD_CAPTURE);
                    4: burst_bytes.push_back(CMD_BEEP);
                    default: burst_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
                endcase
        end
        else
        begin
            burst_bytes.push_back(HDR_FIRST);
            burst_bytes.push_back(HDR_SECOND);
            burst_bytes.push_back(CMD_CAPTURE);
            foreach (pay[i])
                burst_bytes.push_back(pay[i]);
            burst_bytes.push_back(trailer);
        end
    endfunction

    task automatic send_beat(input logic [BYTE_W-1:0] b, input row_kind_t kind,
                             input logic rq, input logic bp);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        advance_frame_state(b);
        case (kind)
            TYPED_NONE:
            begin
            end
            TYPED_FLAG_BEAT:
                beats_due.push_back('{1'b0, '0, '0, rq, bp, 1'b1});
            default:
                foreach (step_beats[i])
                    beats_due.push_back(step_beats[i]);
        endcase
        bytes_sent++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : beat_check
        param_beat_t seen;
        param_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{word_valid, word_index, word_bits, read_request, ack_beep, run_end};
            if (beats_due.size() == 0)
                log_mismatch("unexpected beat", '0, seen);
            else
            begin
                want = beats_due.pop_front();
                if (seen !== want)
                    log_mismatch("beat mismatch", want, seen);
                if (want.word_valid)
                    words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("tb_param_frame_receiver failed");
                $finish;
            end
        end
    end

    initial
    begin : output_drain
        int n;
        wait (rst_n == 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 3);
                out_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int          pick;
        bit          first_seq;
        bit          seq_gaps;
        frame_kind_t kind;
        foreach (payload_copy[i])
            payload_copy[i] = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gaps_on = 1'b1;
        for (int i = 0; i < DIR_N; i++)
            send_beat(DIR_ROWS[i].rx, DIR_ROWS[i].kind, DIR_ROWS[i].rq, DIR_ROWS[i].bp);

        first_seq = 1'b1;
        while (bytes_sent < ITEM_COUNT)
        begin
            pick = $urandom_range(0, 99);
            if (first_seq)            kind = FR_GOOD;
            else if (pick < 35)       kind = FR_GOOD;
            else if (pick < 55)       kind = FR_CMD_INSIDE;
            else if (pick < 65)       kind = FR_TRAILER_CMD;
            else if (pick < 75)       kind = FR_RESTART;
            else if (pick < 85)       kind = FR_BAD_TRAILER;
            else                      kind = FR_NOISE;
            build_sequence(kind);
            seq_gaps = ($urandom_range(0, 3) != 0);
            foreach (burst_bytes[i])
            begin
                if (bytes_sent < ITEM_COUNT)
                begin
                    gaps_on = seq_gaps && (bytes_sent < ITEM_COUNT - TAIL_ITEMS);
                    // back up the first readout behind a long output stall
                    if (first_seq && i == burst_bytes.size() - 1)
                        hold_pending = 1'b1;
                    send_beat(burst_bytes[i], FROM_MODEL, 1'b0, 1'b0);
                end
            end
            first_seq = 1'b0;
        end
        in_valid <= 1'b0;
        gaps_on = 1'b0;

        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (beats_due.size() != 0)
            mismatches++;
        if (mismatches > REPORT_MAX)
            $display("%0d mismatches in total", mismatches);
        $display("run: %0d bytes, %0d frames, %0d words and %0d command beats checked",
                 bytes_sent, frames_read, words_checked, flag_beats);
        $display("run: commands in payload, restarts, bad trailers, %0d-cycle output hold",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("tb_param_frame_receiver passed");
        else
            $display("tb_param_frame_receiver failed");
        $finish;
    end

endmodule
